// ===== hw/rtl/rws_pkg.sv =====
// Shared constants, types and helpers of the rolling window statistics block.
// No dependencies.
package rws_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int OUT_W  = 22;
    localparam int LEN_W  = 7;
    localparam int MODE_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAT_MODE  = 1'd1;

    localparam logic [MODE_W-1:0] MODE_SUM  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd4;

    localparam longint OUT_MAX = 64'sd2097151;
    localparam longint OUT_MIN = -64'sd2097152;

    typedef struct packed {
        logic ins;   // shift a new sample in at the head
        logic rot;   // rotate the ring one place toward the head
    } t_cell_ctl;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > OUT_MAX) r = OUT_MAX;
            if (v < OUT_MIN) r = OUT_MIN;
            sat_out = r[OUT_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/rws_if.sv =====
// Valid/ready channels of the rolling window statistics block.
// Depends on rws_pkg.
interface rws_in_if #(parameter int SAMPLE_BITS = rws_pkg::DEF_SAMPLE_BITS);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_null;
    logic                          series_start;
    modport source (output valid, sample, sample_null, series_start, input ready);
    modport sink   (input valid, sample, sample_null, series_start, output ready);
endinterface

interface rws_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rws_pkg::OUT_W-1:0] stat_value;
    logic                            stat_null;
    modport source (output valid, stat_value, stat_null, input ready);
    modport sink   (input valid, stat_value, stat_null, output ready);
endinterface

// ===== hw/rtl/rws_cell.sv =====
// One window cell: holds a sample and its null mark; shifts or rotates.
// Depends on rws_pkg.
module rws_cell #(
    parameter int SAMPLE_BITS = rws_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  rws_pkg::t_cell_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_d,
    input  logic                          i_prev_nul,
    input  logic signed [SAMPLE_BITS-1:0] i_next_d,
    input  logic                          i_next_nul,
    output logic signed [SAMPLE_BITS-1:0] o_d,
    output logic                          o_nul
);
    logic signed [SAMPLE_BITS-1:0] r_d;
    logic                          r_nul;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_d   <= i_prev_d;
            r_nul <= i_prev_nul;
        end else if (i_ctl.rot) begin
            r_d   <= i_next_d;
            r_nul <= i_next_nul;
        end
    end

    assign o_d   = r_d;
    assign o_nul = r_nul;
endmodule

// ===== hw/rtl/rws_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module rws_div #(
    parameter int NW = 46,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], fits};
            r_rem <= fits ? DW'(rem_sh - {1'b0, r_dvs}) : DW'(rem_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/rws_isqrt.sv =====
// Floor integer square root, one result bit per cycle.
// Depends on nothing but its parameters.
module rws_isqrt #(
    parameter int NW = 46
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_value,
    output logic          o_done,
    output logic [NW-1:0] o_root
);
    localparam int RW = (NW + 1) / 2;
    localparam int CW = $clog2(RW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_x;
    logic [NW-1:0] r_res;
    logic [NW-1:0] r_bit;
    logic [NW:0]   trial;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_value;
            r_res <= '0;
            r_bit <= NW'(1) << (2 * (RW - 1));
        end else if (r_busy) begin
            if ({1'b0, r_x} >= trial) begin
                r_x   <= NW'({1'b0, r_x} - trial);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res;
endmodule

// ===== hw/rtl/rolling_window_statistics_top.sv =====
// Rolling window statistics: ring of sample cells, serial scan, divider and root.
// Depends on rws_pkg, rws_if, rws_cell, rws_div, rws_isqrt.
//
//   channel   dir   handshake      payload
//   i_smp     in    valid/ready    sample, sample_null, series_start
//   o_res     out   valid/ready    stat_value, stat_null
//   i_cfg_*   in    write enable   index, data (window_len, stat_mode)
//
// Sum, min, max and null results pass through accept, a scan over one full ring turn,
// flush, evaluate and output load. Mean adds the one-bit-per-cycle divider. Std adds
// a product step, the divider and the root. Synchronous active-low reset; the cells
// are not cleared.
// The input is taken only in idle; a full output register stalls the result.
module rolling_window_statistics_top #(
    parameter int MAX_WINDOW  = rws_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = rws_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rws_in_if.sink                         i_smp,
    rws_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [rws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int KW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int NUM_W = SQ_W + CNT_W;
    localparam int DV_W  = 2 * CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_SQRT  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                        r_state;
    logic [rws_pkg::LEN_W-1:0]         r_win_len;
    logic [rws_pkg::MODE_W-1:0]        r_mode;
    logic [CNT_W-1:0]                  r_fill;
    logic [CNT_W-1:0]                  r_n;
    logic [KW-1:0]                     r_k;
    logic signed [SUM_W-1:0]           r_sum;
    logic [SQ_W-1:0]                   r_sq;
    logic [CNT_W-1:0]                  r_nulls;
    logic signed [SAMPLE_BITS-1:0]     r_min;
    logic signed [SAMPLE_BITS-1:0]     r_max;
    logic [2*SAMPLE_BITS-1:0]          r_p_sq;
    logic                              r_p_en;
    logic [NUM_W-1:0]                  r_nsq;
    logic [NUM_W-1:0]                  r_ssq;
    logic                              r_is_std;
    logic signed [rws_pkg::OUT_W-1:0]  r_res_val;
    logic                              r_res_nul;
    logic                              r_out_vld;
    logic signed [rws_pkg::OUT_W-1:0]  r_out_val;
    logic                              r_out_nul;

    logic                              smp_xfer;
    logic [CNT_W-1:0]                  fill_base;
    logic [CNT_W-1:0]                  n_fill;
    logic [CNT_W-1:0]                  w_eff;
    logic                              in_win;
    rws_pkg::t_cell_ctl                cell_ctl;
    logic signed [SAMPLE_BITS-1:0]     cell_d   [MAX_WINDOW];
    logic                              cell_nul [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0]     head_d;
    logic                              head_nul;
    logic signed [SUM_W-1:0]           sum_mag;
    logic                              div_start;
    logic [NUM_W-1:0]                  div_num;
    logic [DV_W-1:0]                   div_dvs;
    logic                              div_done;
    logic [NUM_W-1:0]                  div_q;
    logic                              sq_done;
    logic [NUM_W-1:0]                  sq_root;
    logic signed [NUM_W:0]             mean_s;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= rws_pkg::LEN_W'(1);
            r_mode    <= rws_pkg::MODE_SUM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rws_pkg::REG_WINDOW_LEN: r_win_len <= i_cfg_data[rws_pkg::LEN_W-1:0];
                rws_pkg::REG_STAT_MODE:  r_mode    <= i_cfg_data[rws_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_smp.ready = (r_state == ST_IDLE);
    assign smp_xfer    = i_smp.valid && i_smp.ready;

    always_comb begin
        fill_base = i_smp.series_start ? '0 : r_fill;
        n_fill    = (fill_base < CNT_W'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
        if (r_win_len == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(r_win_len) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(r_win_len);
        end
    end

    // cell ring: new sample enters cell 0; during the scan the ring rotates toward cell 0
    assign cell_ctl.ins = smp_xfer;
    assign cell_ctl.rot = (r_state == ST_SCAN);

    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        rws_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_prev_d   ((gi == 0) ? i_smp.sample : cell_d[(gi + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_prev_nul ((gi == 0) ? i_smp.sample_null
                                   : cell_nul[(gi + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_next_d   (cell_d[(gi + 1) % MAX_WINDOW]),
            .i_next_nul (cell_nul[(gi + 1) % MAX_WINDOW]),
            .o_d        (cell_d[gi]),
            .o_nul      (cell_nul[gi])
        );
    end

    assign head_d   = cell_d[0];
    assign head_nul = cell_nul[0];
    assign in_win   = CNT_W'(r_k) < r_n;

    // scan and accumulate
    always_ff @(posedge i_clk) begin
        if (smp_xfer) begin
            r_sum   <= '0;
            r_sq    <= '0;
            r_nulls <= '0;
            r_n     <= (n_fill < w_eff) ? n_fill : w_eff;
        end else begin
            if (r_state == ST_SCAN && in_win) begin
                r_sum   <= r_sum + SUM_W'(head_d);
                r_nulls <= r_nulls + CNT_W'(head_nul);
                if (r_k == '0 || head_d < r_min) r_min <= head_d;
                if (r_k == '0 || head_d > r_max) r_max <= head_d;
            end
            if (r_p_en) r_sq <= r_sq + SQ_W'(r_p_sq);
        end
        r_p_sq <= (2*SAMPLE_BITS)'(head_d * head_d);
        if (r_state == ST_EVAL) begin
            r_nsq <= NUM_W'(r_n * r_sq);
            r_ssq <= NUM_W'(r_sum * r_sum);
        end
    end

    assign sum_mag = r_sum[SUM_W-1] ? -r_sum : r_sum;

    always_comb begin
        div_start = 1'b0;
        div_num   = NUM_W'(sum_mag);
        div_dvs   = DV_W'(r_n);
        if (r_state == ST_MUL) begin
            div_start = 1'b1;
            div_num   = r_nsq - r_ssq;
            div_dvs   = DV_W'(r_n * r_n);
        end else if (r_state == ST_EVAL && r_nulls == '0 && r_mode == rws_pkg::MODE_MEAN) begin
            div_start = 1'b1;
        end
    end

    rws_div #(.NW(NUM_W), .DW(DV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    rws_isqrt #(.NW(NUM_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_done && r_is_std),
        .i_value (div_q),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign mean_s = r_sum[SUM_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_k       <= '0;
            r_p_en    <= 1'b0;
            r_out_vld <= 1'b0;
            r_is_std  <= 1'b0;
        end else begin
            r_p_en <= (r_state == ST_SCAN) && in_win;
            if (r_state == ST_DONE && (!r_out_vld || o_res.ready)) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (smp_xfer) begin
                        r_fill  <= n_fill;
                        r_k     <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(MAX_WINDOW - 1)) r_state <= ST_FLUSH;
                end
                ST_FLUSH: r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_is_std <= (r_nulls == '0) && (r_mode == rws_pkg::MODE_STD)
                                && (r_n >= CNT_W'(2));
                    if (r_nulls != '0) begin
                        r_res_nul <= 1'b1;
                        r_res_val <= '0;
                        r_state   <= ST_DONE;
                    end else begin
                        case (r_mode)
                            rws_pkg::MODE_SUM: begin
                                r_res_nul <= 1'b0;
                                r_res_val <= rws_pkg::sat_out(64'(r_sum));
                                r_state   <= ST_DONE;
                            end
                            rws_pkg::MODE_MEAN: begin
                                r_res_nul <= 1'b0;
                                r_state   <= ST_DIV;
                            end
                            rws_pkg::MODE_STD: begin
                                if (r_n < CNT_W'(2)) begin
                                    r_res_nul <= 1'b1;
                                    r_res_val <= '0;
                                    r_state   <= ST_DONE;
                                end else begin
                                    r_res_nul <= 1'b0;
                                    r_state   <= ST_MUL;
                                end
                            end
                            rws_pkg::MODE_MIN: begin
                                r_res_nul <= 1'b0;
                                r_res_val <= rws_pkg::sat_out(64'(r_min));
                                r_state   <= ST_DONE;
                            end
                            rws_pkg::MODE_MAX: begin
                                r_res_nul <= 1'b0;
                                r_res_val <= rws_pkg::sat_out(64'(r_max));
                                r_state   <= ST_DONE;
                            end
                            default: begin
                                r_res_nul <= 1'b1;
                                r_res_val <= '0;
                                r_state   <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MUL: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        if (r_is_std) begin
                            r_state <= ST_SQRT;
                        end else begin
                            r_res_val <= rws_pkg::sat_out(64'(mean_s));
                            r_state   <= ST_DONE;
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        r_res_val <= rws_pkg::sat_out($signed({1'b0, 63'(sq_root)}));
                        r_state   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || o_res.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_vld || o_res.ready)) begin
            r_out_val <= r_res_val;
            r_out_nul <= r_res_nul;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.stat_value = r_out_val;
    assign o_res.stat_null  = r_out_nul;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_WINDOW))
        else $error("fill count above window depth");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_k == KW'(MAX_WINDOW - 1)) |=> r_state == ST_FLUSH)
        else $error("scan did not finish after a full ring turn");
    a_nulls_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL |-> r_nulls <= r_n)
        else $error("null count exceeds window size");
    a_win_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL |-> (r_n != '0 && r_n <= r_fill))
        else $error("window size out of range");
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for rolling_window_statistics_top: random and directed sample streams,
// a behavioral window predictor, and field-by-field result checks.
// Depends on rws_pkg, rws_if and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = rws_pkg::DEF_MAX_WINDOW;
    localparam int LIMIT = 2_000_000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_null;
        logic               start;
    } t_sample;

    typedef struct packed {
        logic signed [rws_pkg::OUT_W-1:0] value;
        logic                             is_null;
    } t_stat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [rws_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rws_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    rws_in_if  smp_if ();
    rws_out_if res_if ();

    rolling_window_statistics_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp_if.sink), .o_res(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample pending_q[$];
    t_stat   stat_q[$];
    int      errors = 0;
    longint  cycles = 0;

    // predictor state
    longint     win_val[WIN];
    bit         win_null[WIN];
    int         fill = 0;
    int         wpos = 0;
    int         cur_len = 1;
    logic [2:0] cur_mode = rws_pkg::MODE_SUM;

    function automatic longint clamp_out(longint v);
        if (v > 2097151) return 2097151;
        if (v < -2097152) return -2097152;
        return v;
    endfunction

    function automatic longint floor_root(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_stat predict_stat(t_sample s);
        t_stat o;
        int w, n, p, nulls;
        longint sum, mn, mx, v, val;
        longint unsigned sq, num;
        bit rn;
        sum = 0; sq = 0; nulls = 0; mn = 0; mx = 0; val = 0; rn = 0;
        if (s.start) fill = 0;
        win_val[wpos] = s.sample;
        win_null[wpos] = s.is_null;
        p = wpos;
        wpos = (wpos + 1) % WIN;
        if (fill < WIN) fill++;
        w = (cur_len == 0) ? 1 : cur_len;
        if (w > WIN) w = WIN;
        n = (fill < w) ? fill : w;
        for (int k = 0; k < n; k++) begin
            v = win_val[p];
            if (win_null[p]) nulls++;
            sum += v;
            sq += longint'(v * v);
            if (k == 0 || v < mn) mn = v;
            if (k == 0 || v > mx) mx = v;
            p = (p == 0) ? WIN - 1 : p - 1;
        end
        if (nulls != 0) rn = 1;
        else case (cur_mode)
            rws_pkg::MODE_SUM:  val = clamp_out(sum);
            rws_pkg::MODE_MEAN: val = clamp_out(sum / n);
            rws_pkg::MODE_STD: begin
                if (n < 2) rn = 1;
                else begin
                    num = longint'(n) * sq - longint'(sum * sum);
                    val = floor_root(num / (longint'(n) * n));
                    if (val > 2097151) val = 2097151;
                end
            end
            rws_pkg::MODE_MIN:  val = clamp_out(mn);
            rws_pkg::MODE_MAX:  val = clamp_out(mx);
            default:   rn = 1;
        endcase
        if (rn) val = 0;
        o.value = val[rws_pkg::OUT_W-1:0];
        o.is_null = rn;
        return o;
    endfunction

    // handshake flag sampled at posedge; driver reacts at negedge
    logic in_xfer = 1'b0;
    always @(posedge i_clk) in_xfer <= smp_if.valid && smp_if.ready;

    // driver
    int in_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
            smp_if.sample <= '0;
            smp_if.sample_null <= 1'b0;
            smp_if.series_start <= 1'b0;
        end else if (smp_if.valid && !in_xfer) begin
            // hold
        end else begin
            if (smp_if.valid) begin
                stat_q.insert(stat_q.size(), predict_stat({smp_if.sample, smp_if.sample_null,
                                                           smp_if.series_start}));
                void'(pending_q.pop_front());
                in_gap = $urandom_range(0, 8);
            end
            if (pending_q.size() != 0 && (in_gap == 0 || $urandom_range(0, 3) == 0)) begin
                in_gap = 0;
                smp_if.valid <= 1'b1;
                smp_if.sample <= pending_q[0].sample;
                smp_if.sample_null <= pending_q[0].is_null;
                smp_if.series_start <= pending_q[0].start;
            end else begin
                if (in_gap > 0) in_gap--;
                smp_if.valid <= 1'b0;
            end
        end
    end

    // sink stall and result check
    int out_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else if (out_gap > 0) begin
            out_gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stat e;
        cycles++;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            if (stat_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = stat_q.pop_front();
                if (res_if.stat_value !== e.value) begin
                    $error("stat_value expected %0d got %0d", e.value, res_if.stat_value);
                    errors++;
                end
                if (res_if.stat_null !== e.is_null) begin
                    $error("stat_null expected %0d got %0d", e.is_null, res_if.stat_null);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [rws_pkg::CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[rws_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rws_pkg::REG_WINDOW_LEN) cur_len = val;
        else cur_mode = val[2:0];
    endtask

    // append one sample to the driver's queue
    function automatic void queue_sample(t_sample s);
        pending_q.insert(pending_q.size(), s);
    endfunction

    // wait until the block has drained everything queued so far
    task automatic drain();
        while (pending_q.size() != 0 || smp_if.valid || stat_q.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(int seq_pct);
        t_sample s;
        s.sample = 16'($urandom());
        if ($urandom_range(0, 3) == 0) s.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        s.is_null = ($urandom_range(0, 99) < 3);
        s.start = ($urandom_range(0, 99) < seq_pct);
        return s;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset window of one, extremes, null, series start
        queue_sample('{16'sh7fff, 1'b0, 1'b1});
        queue_sample('{16'sh8000, 1'b0, 1'b0});
        queue_sample('{16'sh0000, 1'b1, 1'b0});
        drain();
        for (int m = 0; m < 8; m++) begin
            write_reg(rws_pkg::REG_STAT_MODE, m);
            write_reg(rws_pkg::REG_WINDOW_LEN, (m == 0) ? 0 : (m == 1) ? 127 : 4);
            queue_sample('{16'sh7fff, 1'b0, 1'b1});
            queue_sample('{16'sh7fff, 1'b0, 1'b0});
            queue_sample('{16'sh8000, 1'b0, 1'b0});
            drain();
        end

        // random phases over window lengths and modes
        for (int ph = 0; ph < 30; ph++) begin
            int len;
            case (ph % 6)
                0: len = 0;
                1: len = 64;
                2: len = 65 + $urandom_range(0, 62);
                3: len = 1;
                default: len = $urandom_range(2, 64);
            endcase
            write_reg(rws_pkg::REG_WINDOW_LEN, len);
            write_reg(rws_pkg::REG_STAT_MODE, (ph % 8 < 5) ? ph % 5 : $urandom_range(0, 7));
            for (int i = 0; i < 55; i++) queue_sample(rand_sample(2));
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

// ===== rolling_window_statistics_top.f =====
hw/rtl/rws_pkg.sv
hw/rtl/rws_if.sv
hw/rtl/rws_cell.sv
hw/rtl/rws_div.sv
hw/rtl/rws_isqrt.sv
hw/rtl/rolling_window_statistics_top.sv
tb/sv/tb_top.sv
